FILE: rtl/lane_homography_backproject_core_macros.svh
// Assertion macros for the lane homography back-projection core.
`ifndef LANE_HOMOGRAPHY_BACKPROJECT_CORE_MACROS_SVH
`define LANE_HOMOGRAPHY_BACKPROJECT_CORE_MACROS_SVH

// Condition checked at every edge outside reset.
`define LHB_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition on one edge implies a condition on the next edge.
`define LHB_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/lhb_pkg.sv
// Package for the lane homography back-projection core: types, constants, helpers.
package lhb_pkg;

   localparam int FRAME_HEIGHT = 720;
   localparam int MAX_LANES    = 5;

   localparam int COEF_W  = 40;
   localparam int PIX_W   = 16;
   localparam int Q8_W    = 24;
   localparam int ACC_W   = 58;
   localparam int MA_W    = COEF_W + 1;
   localparam int MB_W    = 26;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int REM_W   = ACC_W + 24;
   localparam int QD_W    = 25;
   localparam int IDX_W   = 4;
   localparam int STG_W   = 5;
   localparam int DCNT_W  = 5;

   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(QD_W + 1);

   localparam logic signed [Q8_W-1:0] Q8_MAX = 24'sh7FFFFF;
   localparam logic signed [Q8_W-1:0] Q8_MIN = 24'sh800000;
   localparam logic [Q8_W-1:0] Q8_LIM = 24'h800000;

   localparam logic signed [ACC_W-1:0] ONE_Q24 = ACC_W'(64'sd16777216);
   localparam logic signed [MB_W-1:0] BOTTOM_Q8 = MB_W'(FRAME_HEIGHT * 256);

   localparam logic [IDX_W-1:0] CSR_C00   = 4'd0;
   localparam logic [IDX_W-1:0] CSR_C11   = 4'd4;
   localparam logic [IDX_W-1:0] CSR_COUNT = 4'd8;

   localparam logic [2:0] SUB_WX   = 3'd0;
   localparam logic [2:0] SUB_WY   = 3'd1;
   localparam logic [2:0] SUB_NXX  = 3'd2;
   localparam logic [2:0] SUB_NXY  = 3'd3;
   localparam logic [2:0] SUB_NYX  = 3'd4;
   localparam logic [2:0] SUB_NYY  = 3'd5;
   localparam logic [2:0] SUB_DIVX = 3'd6;
   localparam logic [2:0] SUB_DIVY = 3'd7;

   localparam logic [STG_W-1:0] STG_FIRST    = 5'd0;
   localparam logic [STG_W-1:0] STG_MAC1_END = 5'd13;
   localparam logic [STG_W-1:0] STG_MAC0_END = 5'd5;
   localparam logic [STG_W-1:0] STG_DIVY0    = 5'd7;
   localparam logic [STG_W-1:0] STG_DIVY1    = 5'd15;
   localparam logic [STG_W-1:0] STG_SLOPE    = 5'd16;
   localparam logic [STG_W-1:0] STG_BOTTOM   = 5'd17;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MAC  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_BOOK = 4'b1000
   } state_type;

   // Q16.8 to integer pixels, truncated toward zero.
   function automatic logic [PIX_W-1:0] q8_to_pix(input logic [Q8_W-1:0] v);
      logic [Q8_W-1:0] adj;
      adj = v + (v[Q8_W-1] ? Q8_W'(255) : Q8_W'(0));
      return adj[Q8_W-1:8];
   endfunction

   function automatic logic [ACC_W-1:0] mag(input logic [ACC_W-1:0] v);
      return v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
   endfunction

endpackage

FILE: rtl/lane_homography_backproject_core.sv
// Lane homography back-projection core: shared MAC and divider under a stage sequencer.
//
//  channel  | handshake            | payload
//  req      | req_valid/req_stall  | seg_start_x/y, seg_end_x/y, last_lane
//  rsp      | rsp_valid/rsp_stall  | orig_start_x/y, orig_bottom_x, frame_end, arrow_*
//  csr      | csr_valid/csr_ready  | csr_index, csr_data
//
// Each beat takes 13 MAC steps and five divides on one divider.
// The divider (one 82-bit compare/subtract per cycle) takes most of the time of a beat.
// A new beat is taken once the sequencer is idle; a held result does not block it.
// Reset (synchronous) restores the identity matrix and clears all frame state.
`include "lane_homography_backproject_core_macros.svh"

module lane_homography_backproject_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [15:0] req_seg_start_x,
   input  logic signed [15:0] req_seg_start_y,
   input  logic signed [15:0] req_seg_end_x,
   input  logic signed [15:0] req_seg_end_y,
   input  logic        req_last_lane,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_orig_start_x,
   output logic signed [15:0] rsp_orig_start_y,
   output logic signed [15:0] rsp_orig_bottom_x,
   output logic        rsp_frame_end,
   output logic        rsp_arrow_present,
   output logic signed [15:0] rsp_arrow_pos_x,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [39:0] csr_data
);

   lhb_pkg::state_type state_ff, state_in;
   logic [lhb_pkg::STG_W-1:0] stage_ff, stage_in;
   logic [lhb_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;

   logic [lhb_pkg::COEF_W-1:0] coef_ff [8];

   logic [lhb_pkg::PIX_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic last_ff;

   logic [lhb_pkg::ACC_W-1:0] acc_ff, acc_in, w_ff, w_in, nx_ff, nx_in, ny_ff, ny_in;
   logic [lhb_pkg::Q8_W-1:0] pax_ff, pax_in, pay_ff, pay_in, pbx_ff, pbx_in;
   logic [lhb_pkg::Q8_W-1:0] pby_ff, pby_in, qb_ff, qb_in;

   logic [lhb_pkg::REM_W-1:0] rem_ff, rem_in, dv_ff, dv_in;
   logic [lhb_pkg::QD_W-1:0] q_ff, q_in;
   logic neg_ff, neg_in, zero_ff, zero_in, nneg_ff, nneg_in;

   logic [lhb_pkg::Q8_W-1:0] pbot_ff, pbot_in, pst_ff, pst_in;
   logic [lhb_pkg::Q8_W:0] widest_ff, widest_in;
   logic [lhb_pkg::PIX_W-1:0] gapc_ff, gapc_in, arrow_ff, arrow_in;
   logic [2:0] lanes_ff, lanes_in;
   logic arrow_set_ff, arrow_set_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [lhb_pkg::PIX_W-1:0] o_sx_ff, o_sx_in, o_sy_ff, o_sy_in, o_bx_ff, o_bx_in;
   logic o_fe_ff, o_fe_in;

   logic [2:0] sub;
   logic pt;
   logic [lhb_pkg::PIX_W-1:0] cx, cy;
   logic signed [lhb_pkg::MA_W-1:0] ma;
   logic signed [lhb_pkg::MB_W-1:0] mb;
   logic signed [lhb_pkg::PROD_W-1:0] prod;
   logic [lhb_pkg::ACC_W-1:0] base, mac_sum;
   logic [lhb_pkg::Q8_W:0] dx, dy;
   logic signed [lhb_pkg::MB_W-1:0] tq;

   logic [lhb_pkg::ACC_W-1:0] dnum, dden;
   logic dsh8, ge;
   logic [lhb_pkg::Q8_W-1:0] mq, dres;

   logic [lhb_pkg::Q8_W:0] bsum, diff, ssum, sadj, sshift;
   logic [lhb_pkg::Q8_W-1:0] bottom;
   logic [3:0] count;
   logic accept, book_go, upd;
   logic [lhb_pkg::Q8_W:0] wg_new;
   logic [lhb_pkg::PIX_W-1:0] gc_new;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != lhb_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign sub = stage_ff[2:0];
   assign pt  = stage_ff[3];
   assign cx  = pt ? ex_ff : sx_ff;
   assign cy  = pt ? ey_ff : sy_ff;
   assign dx  = {pbx_ff[lhb_pkg::Q8_W-1], pbx_ff} - {pax_ff[lhb_pkg::Q8_W-1], pax_ff};
   assign dy  = {pby_ff[lhb_pkg::Q8_W-1], pby_ff} - {pay_ff[lhb_pkg::Q8_W-1], pay_ff};
   assign tq  = lhb_pkg::BOTTOM_Q8 - $signed({{2{pay_ff[lhb_pkg::Q8_W-1]}}, pay_ff});

   // shared multiply-accumulate operands
   always_comb begin
      ma   = '0;
      base = acc_ff;
      case (sub)
         lhb_pkg::SUB_WX: begin
            ma   = $signed({coef_ff[6][39], coef_ff[6]});
            base = lhb_pkg::ONE_Q24;
         end
         lhb_pkg::SUB_WY:  ma = $signed({coef_ff[7][39], coef_ff[7]});
         lhb_pkg::SUB_NXX: begin
            ma   = $signed({coef_ff[0][39], coef_ff[0]});
            base = {{18{coef_ff[2][39]}}, coef_ff[2]};
         end
         lhb_pkg::SUB_NXY: ma = $signed({coef_ff[1][39], coef_ff[1]});
         lhb_pkg::SUB_NYX: begin
            ma   = $signed({coef_ff[3][39], coef_ff[3]});
            base = {{18{coef_ff[5][39]}}, coef_ff[5]};
         end
         lhb_pkg::SUB_NYY: ma = $signed({coef_ff[4][39], coef_ff[4]});
         default: ma = '0;
      endcase
      mb = sub[0] ? $signed({{10{cy[15]}}, cy}) : $signed({{10{cx[15]}}, cx});
      if (stage_ff == lhb_pkg::STG_SLOPE) begin
         ma   = $signed({{16{dx[24]}}, dx});
         mb   = tq;
         base = '0;
      end
   end

   assign prod    = ma * mb;
   assign mac_sum = base + prod[lhb_pkg::ACC_W-1:0];

   // divider operands and result
   always_comb begin
      dnum = nx_ff;
      dden = w_ff;
      dsh8 = 1'b1;
      if (stage_ff == lhb_pkg::STG_BOTTOM) begin
         dden = {{33{dy[24]}}, dy};
         dsh8 = 1'b0;
      end else if (sub == lhb_pkg::SUB_DIVY) begin
         dnum = ny_ff;
      end
   end

   assign ge = (rem_ff >= dv_ff);

   always_comb begin
      if (q_ff[lhb_pkg::QD_W-1] || (q_ff[lhb_pkg::Q8_W-1:0] > lhb_pkg::Q8_LIM)) begin
         mq = lhb_pkg::Q8_LIM;
      end else begin
         mq = q_ff[lhb_pkg::Q8_W-1:0];
      end
      if (zero_ff) begin
         dres = nneg_ff ? lhb_pkg::Q8_MIN : lhb_pkg::Q8_MAX;
      end else if (neg_ff) begin
         dres = ~mq + lhb_pkg::Q8_W'(1);
      end else if (mq == lhb_pkg::Q8_LIM) begin
         dres = lhb_pkg::Q8_MAX;
      end else begin
         dres = mq;
      end
   end

   // lane bookkeeping
   always_comb begin
      bsum = {pax_ff[23], pax_ff} + {qb_ff[23], qb_ff};
      if (zero_ff) begin
         bottom = qb_ff;
      end else if (bsum[24] != bsum[23]) begin
         bottom = bsum[24] ? lhb_pkg::Q8_MIN : lhb_pkg::Q8_MAX;
      end else begin
         bottom = bsum[23:0];
      end
      diff   = {pbot_ff[23], pbot_ff} - {bottom[23], bottom};
      ssum   = {pst_ff[23], pst_ff} + {pax_ff[23], pax_ff};
      sadj   = ssum + (ssum[24] ? 25'd511 : 25'd0);
      sshift = $signed(sadj) >>> 9;
      upd    = (lanes_ff != 3'd0) && !pbot_ff[23] && !bottom[23]
               && ($signed(diff) < $signed(widest_ff));
      wg_new = upd ? diff : widest_ff;
      gc_new = upd ? sshift[15:0] : gapc_ff;
      count  = {1'b0, lanes_ff} + 4'd1;
   end

   assign book_go = (state_ff == lhb_pkg::ST_BOOK) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      dcnt_in  = dcnt_ff;
      acc_in = acc_ff;  w_in = w_ff;  nx_in = nx_ff;  ny_in = ny_ff;
      pax_in = pax_ff;  pay_in = pay_ff;  pbx_in = pbx_ff;  pby_in = pby_ff;  qb_in = qb_ff;
      rem_in = rem_ff;  dv_in = dv_ff;  q_in = q_ff;
      neg_in = neg_ff;  zero_in = zero_ff;  nneg_in = nneg_ff;
      pbot_in = pbot_ff;  pst_in = pst_ff;  widest_in = widest_ff;  gapc_in = gapc_ff;
      lanes_in = lanes_ff;  arrow_in = arrow_ff;  arrow_set_in = arrow_set_ff;
      o_sx_in = o_sx_ff;  o_sy_in = o_sy_ff;  o_bx_in = o_bx_ff;  o_fe_in = o_fe_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         lhb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lhb_pkg::ST_MAC;
               stage_in = lhb_pkg::STG_FIRST;
            end
         end
         lhb_pkg::ST_MAC: begin
            if (stage_ff == lhb_pkg::STG_SLOPE) begin
               nx_in = mac_sum;
            end else begin
               case (sub)
                  lhb_pkg::SUB_WY:  w_in  = mac_sum;
                  lhb_pkg::SUB_NXY: nx_in = mac_sum;
                  lhb_pkg::SUB_NYY: ny_in = mac_sum;
                  default:          acc_in = mac_sum;
               endcase
            end
            stage_in = stage_ff + lhb_pkg::STG_W'(1);
            if (stage_ff == lhb_pkg::STG_MAC0_END || stage_ff == lhb_pkg::STG_MAC1_END
                || stage_ff == lhb_pkg::STG_SLOPE) begin
               state_in = lhb_pkg::ST_DIV;
               dcnt_in  = '0;
            end
         end
         lhb_pkg::ST_DIV: begin
            if (dcnt_ff == '0) begin
               rem_in  = dsh8 ? {16'd0, lhb_pkg::mag(dnum), 8'd0}
                              : {24'd0, lhb_pkg::mag(dnum)};
               dv_in   = {lhb_pkg::mag(dden), 24'd0};
               q_in    = '0;
               neg_in  = dnum[lhb_pkg::ACC_W-1] ^ dden[lhb_pkg::ACC_W-1];
               nneg_in = dnum[lhb_pkg::ACC_W-1];
               zero_in = (dden == '0);
               dcnt_in = dcnt_ff + lhb_pkg::DCNT_W'(1);
            end else if (dcnt_ff != lhb_pkg::DIV_LAST) begin
               rem_in  = ge ? (rem_ff - dv_ff) : rem_ff;
               dv_in   = dv_ff >> 1;
               q_in    = {q_ff[lhb_pkg::QD_W-2:0], ge};
               dcnt_in = dcnt_ff + lhb_pkg::DCNT_W'(1);
            end else begin
               dcnt_in  = '0;
               stage_in = stage_ff + lhb_pkg::STG_W'(1);
               if (stage_ff == lhb_pkg::STG_BOTTOM) begin
                  qb_in    = dres;
                  state_in = lhb_pkg::ST_BOOK;
               end else begin
                  case ({pt, sub[0]})
                     2'b00:   pax_in = dres;
                     2'b01:   pay_in = dres;
                     2'b10:   pbx_in = dres;
                     default: pby_in = dres;
                  endcase
                  if (stage_ff == lhb_pkg::STG_DIVY0 || stage_ff == lhb_pkg::STG_DIVY1) begin
                     state_in = lhb_pkg::ST_MAC;
                  end
               end
            end
         end
         lhb_pkg::ST_BOOK: begin
            if (book_go) begin
               state_in     = lhb_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               pbot_in      = bottom;
               pst_in       = pax_ff;
               widest_in    = wg_new;
               gapc_in      = gc_new;
               if (last_ff) begin
                  if (count <= 4'(lhb_pkg::MAX_LANES) && wg_new != '0) begin
                     arrow_in     = gc_new;
                     arrow_set_in = 1'b1;
                  end
                  lanes_in  = '0;
                  widest_in = '0;
                  gapc_in   = '0;
               end else if (lanes_ff != 3'd7) begin
                  lanes_in = lanes_ff + 3'd1;
               end
               o_sx_in = lhb_pkg::q8_to_pix(pax_ff);
               o_sy_in = lhb_pkg::q8_to_pix(pay_ff);
               o_bx_in = lhb_pkg::q8_to_pix(bottom);
               o_fe_in = last_ff;
            end
         end
         default: state_in = lhb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lhb_pkg::ST_IDLE;
         stage_ff     <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pbot_ff      <= '0;
         pst_ff       <= '0;
         widest_ff    <= '0;
         gapc_ff      <= '0;
         lanes_ff     <= '0;
         arrow_ff     <= '0;
         arrow_set_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            coef_ff[i] <= (i == int'(lhb_pkg::CSR_C00) || i == int'(lhb_pkg::CSR_C11))
                          ? 40'd16777216 : 40'd0;
         end
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pbot_ff      <= pbot_in;
         pst_ff       <= pst_in;
         widest_ff    <= widest_in;
         gapc_ff      <= gapc_in;
         lanes_ff     <= lanes_in;
         arrow_ff     <= arrow_in;
         arrow_set_ff <= arrow_set_in;
         if (csr_valid && csr_ready && csr_index < lhb_pkg::CSR_COUNT) begin
            coef_ff[csr_index[2:0]] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sx_ff   <= req_seg_start_x;
         sy_ff   <= req_seg_start_y;
         ex_ff   <= req_seg_end_x;
         ey_ff   <= req_seg_end_y;
         last_ff <= req_last_lane;
      end
      acc_ff <= acc_in;  w_ff <= w_in;  nx_ff <= nx_in;  ny_ff <= ny_in;
      pax_ff <= pax_in;  pay_ff <= pay_in;  pbx_ff <= pbx_in;  pby_ff <= pby_in;
      qb_ff  <= qb_in;
      rem_ff <= rem_in;  dv_ff <= dv_in;  q_ff <= q_in;
      neg_ff <= neg_in;  zero_ff <= zero_in;  nneg_ff <= nneg_in;
      o_sx_ff <= o_sx_in;  o_sy_ff <= o_sy_in;  o_bx_ff <= o_bx_in;  o_fe_ff <= o_fe_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_orig_start_x  = o_sx_ff;
   assign rsp_orig_start_y  = o_sy_ff;
   assign rsp_orig_bottom_x = o_bx_ff;
   assign rsp_frame_end     = o_fe_ff;
   assign rsp_arrow_present = arrow_set_ff;
   assign rsp_arrow_pos_x   = arrow_ff;

   `LHB_ASSERT_ALWAYS(a_gap_not_positive, widest_ff[24] || widest_ff == '0, "widest gap positive")
   `LHB_ASSERT_ALWAYS(a_div_count_range, dcnt_ff <= lhb_pkg::DIV_LAST, "divider count overrun")
   `LHB_ASSERT_NEXT(a_rsp_from_book, !rsp_valid_ff, !rsp_valid_ff || $past(book_go), "stray result")
   `LHB_ASSERT_NEXT(a_arrow_sticky, arrow_set_ff, arrow_set_ff, "arrow flag dropped")

endmodule

FILE: tb/lane_homography_backproject_core_test.sv
// Self-checking testbench for the lane homography back-projection core.
module lane_homography_backproject_core_test;

   localparam longint ONE = 64'sd16777216;
   localparam longint SAT_HI = 64'sd8388607;
   localparam longint SAT_LO = -64'sd8388608;
   localparam int COEF_COUNT = 8;
   localparam int C20 = 6;

   typedef struct {
      logic signed [15:0] sx, sy, ex, ey;
      logic last;
   } seg_type;

   typedef struct {
      logic signed [15:0] start_x, start_y, bottom_x;
      logic frame_end, arrow_present;
      logic signed [15:0] arrow_x;
   } lane_res_type;

   typedef struct {
      seg_type seg;
      bit typed;
      lane_res_type want;
   } plan_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_seg_start_x = 0, req_seg_start_y = 0;
   logic signed [15:0] req_seg_end_x = 0, req_seg_end_y = 0;
   logic req_last_lane = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_orig_start_x, rsp_orig_start_y, rsp_orig_bottom_x;
   logic rsp_frame_end, rsp_arrow_present;
   logic signed [15:0] rsp_arrow_pos_x;
   logic csr_valid = 0;
   logic csr_ready;
   logic [3:0] csr_index = 0;
   logic [39:0] csr_data = 0;

   lane_homography_backproject_core u_dut (.*);

   always #5 clock = ~clock;

   // matrix and frame bookkeeping mirrored from the block
   longint coef_m[COEF_COUNT];
   longint last_bottom, last_start, gap_min, gap_mid, arrow_x;
   int lanes_in_frame;
   bit arrow_valid;

   lane_res_type pending_q[$];
   int errors = 0;
   int results_seen = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit hold_request = 0;

   function automatic longint clamp24(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // truncating divide with saturation; shift is 0 or 8
   function automatic longint quotient_sat(longint num, longint den, bit shift8);
      bit [63:0] un, ud, q, r, m;
      bit neg;
      if (den == 0) return (num < 0) ? SAT_LO : SAT_HI;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? 64'(-num) : 64'(num);
      ud = (den < 0) ? 64'(-den) : 64'(den);
      q = un / ud;
      r = un % ud;
      if (shift8) begin
         if (q >= 64'd32768) m = 64'd8388608;
         else m = (q << 8) + ((r << 8) / ud);
      end else begin
         m = q;
      end
      if (m > 64'd8388608) m = 64'd8388608;
      return neg ? clamp24(-longint'(m)) : clamp24(longint'(m));
   endfunction

   function automatic lane_res_type project_lane(seg_type s);
      lane_res_type res;
      longint x1, y1, x2, y2, w1, w2, px1, py1, px2, py2, dx, dy, num, bottom, diff;
      int count;
      x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
      w1 = coef_m[6] * x1 + coef_m[7] * y1 + ONE;
      w2 = coef_m[6] * x2 + coef_m[7] * y2 + ONE;
      px1 = quotient_sat(coef_m[0] * x1 + coef_m[1] * y1 + coef_m[2], w1, 1);
      py1 = quotient_sat(coef_m[3] * x1 + coef_m[4] * y1 + coef_m[5], w1, 1);
      px2 = quotient_sat(coef_m[0] * x2 + coef_m[1] * y2 + coef_m[2], w2, 1);
      py2 = quotient_sat(coef_m[3] * x2 + coef_m[4] * y2 + coef_m[5], w2, 1);
      dx = px2 - px1;
      dy = py2 - py1;
      num = (longint'(lhb_pkg::FRAME_HEIGHT) * 256 - py1) * dx;
      if (dy == 0) bottom = (num < 0) ? SAT_LO : SAT_HI;
      else bottom = clamp24(px1 + quotient_sat(num, dy, 0));
      if (lanes_in_frame >= 1 && last_bottom >= 0 && bottom >= 0) begin
         diff = last_bottom - bottom;
         if (diff < gap_min) begin
            gap_min = diff;
            gap_mid = (last_start + px1) / 512;
         end
      end
      count = lanes_in_frame + 1;
      last_bottom = bottom;
      last_start = px1;
      if (s.last) begin
         if (count <= lhb_pkg::MAX_LANES && gap_min != 0) begin
            arrow_x = gap_mid;
            arrow_valid = 1;
         end
         lanes_in_frame = 0;
         gap_min = 0;
         gap_mid = 0;
      end else if (lanes_in_frame < 7) begin
         lanes_in_frame++;
      end
      res.start_x = 16'(px1 / 256);
      res.start_y = 16'(py1 / 256);
      res.bottom_x = 16'(bottom / 256);
      res.frame_end = s.last;
      res.arrow_present = arrow_valid;
      res.arrow_x = 16'(arrow_x);
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      lane_res_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            exp_res = pending_q[0];
            pending_q.delete(0);
            if (rsp_orig_start_x !== exp_res.start_x)
               report_mismatch("orig_start_x", rsp_orig_start_x, exp_res.start_x);
            if (rsp_orig_start_y !== exp_res.start_y)
               report_mismatch("orig_start_y", rsp_orig_start_y, exp_res.start_y);
            if (rsp_orig_bottom_x !== exp_res.bottom_x)
               report_mismatch("orig_bottom_x", rsp_orig_bottom_x, exp_res.bottom_x);
            if (rsp_frame_end !== exp_res.frame_end)
               report_mismatch("frame_end", rsp_frame_end, exp_res.frame_end);
            if (rsp_arrow_present !== exp_res.arrow_present)
               report_mismatch("arrow_present", rsp_arrow_present, exp_res.arrow_present);
            if (rsp_arrow_pos_x !== exp_res.arrow_x)
               report_mismatch("arrow_pos_x", rsp_arrow_pos_x, exp_res.arrow_x);
         end
         results_seen++;
      end
   end

   // receiver stall, with an optional long hold counted here
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = 600;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_lane(seg_type s, bit typed, lane_res_type want);
      lane_res_type got;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_seg_start_x <= s.sx;
      req_seg_start_y <= s.sy;
      req_seg_end_x <= s.ex;
      req_seg_end_y <= s.ey;
      req_last_lane <= s.last;
      do @(posedge clock); while (req_stall);
      got = project_lane(s);
      if (typed) got = want;
      pending_q.insert(pending_q.size(), got);
   endtask

   task automatic write_csr(int idx, longint value);
      csr_valid <= 1;
      csr_index <= 4'(idx);
      csr_data <= 40'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx < COEF_COUNT) coef_m[idx] = value;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      wait (pending_q.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_coord(bit wide, int span);
      if (wide) return 16'($urandom);
      return 16'($urandom_range(span));
   endfunction

   initial begin
      plan_row_type plan[$];
      lane_res_type none;
      seg_type s;
      int lanes, budget, count_items;
      bit wide;
      longint v;

      none = '{0, 0, 0, 0, 0, 0};
      foreach (coef_m[i]) coef_m[i] = 0;
      coef_m[0] = ONE;
      coef_m[4] = ONE;
      last_bottom = 0; last_start = 0; gap_min = 0; gap_mid = 0; arrow_x = 0;
      lanes_in_frame = 0;
      arrow_valid = 0;
      count_items = 0;

      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // identity matrix after reset
      plan.insert(plan.size(), '{'{100, 200, 100, 700, 0}, 1, '{100, 200, 100, 0, 0, 0}});
      plan.insert(plan.size(), '{'{0, 300, 50, 300, 1}, 1, '{0, 300, 32767, 1, 1, 50}});
      plan.insert(plan.size(), '{'{-32768, -32768, 32767, 32767, 0}, 1,
                                 '{-32768, -32768, 0, 0, 1, 50}});
      plan.insert(plan.size(), '{'{32767, 32767, -32768, -32768, 1}, 0, none});
      for (int i = 0; i < 7; i++)
         plan.insert(plan.size(),
                     '{'{16'(100 * i), 0, 16'(100 * i + 40 * i), 500, i == 6}, 0, none});
      plan.insert(plan.size(), '{'{-500, 100, -600, 400, 0}, 0, none});
      plan.insert(plan.size(), '{'{-900, 100, -1200, 400, 1}, 0, none});
      plan.insert(plan.size(), '{'{640, 10, 700, 400, 1}, 0, none});
      plan.insert(plan.size(), '{'{200, 100, 180, 600, 0}, 0, none});
      plan.insert(plan.size(), '{'{900, 100, 1000, 600, 1}, 0, none});
      foreach (plan[i]) begin
         send_lane(plan[i].seg, plan[i].typed, plan[i].want);
         count_items++;
      end
      drain();

      // projective row cancels the unit term at x = 1: zero divisor
      write_csr(C20, -ONE);
      send_lane('{1, 5, 1, 9, 0}, 0, none);
      send_lane('{1, -5, 2, 9, 0}, 0, none);
      send_lane('{3, 40, 1, -9, 1}, 0, none);
      count_items += 3;
      drain();

      for (int p = 0; p < 7; p++) begin
         for (int r = 0; r < COEF_COUNT; r++) begin
            if (p == 1) v = 64'sd549755813887;
            else if (p == 2) v = -64'sd549755813888;
            else if (r == 0 || r == 4) v = ONE + $signed($urandom_range(8388608)) - 4194304;
            else if (r == 2 || r == 5) v = $signed($urandom_range(2147483647)) - 1073741824;
            else if (r >= 6) v = $signed($urandom_range(8192)) - 4096;
            else v = $signed($urandom_range(4194304)) - 2097152;
            write_csr(r, v);
         end
         write_csr($urandom_range(15, COEF_COUNT), 64'(ONE));
         case (p % 4)
            0: begin send_gap_pct = 0; stall_pct = 0; end
            1: begin send_gap_pct = 46; stall_pct = 0; end
            2: begin send_gap_pct = 0; stall_pct = 46; end
            default: begin send_gap_pct = 11; stall_pct = 11; end
         endcase
         budget = (p == 1 || p == 2) ? 60 : 345;
         if (p == 3) hold_request = 1;
         while (budget > 0) begin
            lanes = ($urandom_range(9) == 0) ? $urandom_range(7, 6) : $urandom_range(5, 1);
            for (int k = 0; k < lanes; k++) begin
               wide = ($urandom_range(7) == 0);
               s.sx = rand_coord(wide, 1279);
               s.sy = rand_coord(wide, 719);
               s.ex = rand_coord(wide, 1279);
               s.ey = rand_coord(wide, 719);
               s.last = (k == lanes - 1) ? ($urandom_range(15) != 0) : 0;
               send_lane(s, 0, none);
               budget--;
               count_items++;
            end
            if (p == 4 && budget < 200 && budget > 190) begin
               req_valid <= 0;
               wait (pending_q.size() == 0);
            end
         end
         drain();
      end

      $display("covered %0d lane beats, %0d results, under identity, zero-divisor,",
               count_items, results_seen);
      $display("saturated and random matrices with idle, stall and long-hold phases");
      if (errors == 0 && pending_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("timeout with %0d results outstanding", pending_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
